@@ src/cle_pkg.sv @@
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types, constants and Q15 arithmetic helpers for the complex LMS
// equalizer.
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam int unsigned TapsDefault = 16;
    localparam int unsigned CfgIdxW     = 1;
    localparam int unsigned CfgDataW    = 16;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_STEP_RE = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_STEP_IM = 1'd1;

    typedef struct packed {
        logic signed [15:0] rx_re;
        logic signed [15:0] rx_im;
        logic signed [15:0] desired_re;
        logic signed [15:0] desired_im;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] y_re;
        logic signed [15:0] y_im;
        logic signed [15:0] err_re;
        logic signed [15:0] err_im;
    } t_out_item;

    // datapath operation selects
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_SHIFT,
        OP_ACC_RE,
        OP_ACC_IM,
        OP_ERR,
        OP_STEPS,
        OP_UPD,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
    } t_dp_cmd;

    // saturating Q15 x Q15 -> Q31 product
    function automatic logic signed [31:0] fmul(input logic signed [15:0] a,
                                                input logic signed [15:0] b);
        logic signed [31:0] p;
        begin
            p = a * b;
            if (p == 32'sh4000_0000) fmul = 32'sh7fff_ffff;
            else fmul = {p[30:0], 1'b0};
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        if (v > 33'sh0_7fff_ffff) sat32 = 32'sh7fff_ffff;
        else if (v < -33'sh0_8000_0000) sat32 = 32'sh8000_0000;
        else sat32 = v[31:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        if (v > 17'sd32767) sat16 = 16'sh7fff;
        else if (v < -17'sd32768) sat16 = 16'sh8000;
        else sat16 = v[15:0];
    endfunction

    // Q31 -> Q15 rounded with saturation of the rounding carry
    function automatic logic signed [15:0] rnd15(input logic signed [31:0] acc);
        logic signed [31:0] s;
        begin
            s = sat32({acc[31], acc} + 33'sh0_0000_8000);
            rnd15 = s[31:16];
        end
    endfunction

endpackage

@@ src/cle_ctrl.sv @@
// ----------------------------------------------------------------------------
// cle_ctrl
// Sequencer: steps the datapath through shift, two accumulate passes,
// error, step products, the coefficient update pass and the result load.
// ----------------------------------------------------------------------------
module cle_ctrl #(
    parameter int unsigned TAPS = cle_pkg::TapsDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [((TAPS > 1) ? $clog2(TAPS) : 1)-1:0] o_tap,
    output cle_pkg::t_dp_cmd o_cmd
);
    import cle_pkg::*;

    localparam int unsigned TapW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam logic [TapW-1:0] LastTap = TapW'(TAPS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACCR  = 3'd1;
    localparam logic [2:0] S_ACCI  = 3'd2;
    localparam logic [2:0] S_ERR   = 3'd3;
    localparam logic [2:0] S_STEPS = 3'd4;
    localparam logic [2:0] S_UPD   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]      r_state, n_state;
    logic [TapW-1:0] r_tap, n_tap;
    logic            r_ov, n_ov;
    logic            w_take;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_take      = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_tap       = r_tap;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        n_ov    = r_ov && i_out_stall;
        o_cmd   = '{op: OP_IDLE};
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    o_cmd   = '{op: OP_SHIFT};
                    n_state = S_ACCR;
                    n_tap   = '0;
                end
            end
            S_ACCR: begin
                o_cmd = '{op: OP_ACC_RE};
                n_tap = r_tap + 1'b1;
                if (r_tap == LastTap) begin
                    n_tap   = '0;
                    n_state = S_ACCI;
                end
            end
            S_ACCI: begin
                o_cmd = '{op: OP_ACC_IM};
                n_tap = r_tap + 1'b1;
                if (r_tap == LastTap) begin
                    n_tap   = '0;
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd   = '{op: OP_ERR};
                n_state = S_STEPS;
            end
            S_STEPS: begin
                o_cmd   = '{op: OP_STEPS};
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd = '{op: OP_UPD};
                n_tap = r_tap + 1'b1;
                if (r_tap == LastTap) begin
                    n_tap   = '0;
                    n_state = S_OUT;
                end
            end
            // load the result register once the previous result has left
            S_OUT: begin
                if (!r_ov) begin
                    o_cmd   = '{op: OP_OUT};
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
            r_ov    <= n_ov;
        end
    end

endmodule

@@ src/cle_dp.sv @@
// ----------------------------------------------------------------------------
// cle_dp
// Datapath: delay line, coefficient store, step registers, two shared
// complex-product MAC lanes, the error and update arithmetic and the
// result register.
// ----------------------------------------------------------------------------
module cle_dp #(
    parameter int unsigned TAPS = cle_pkg::TapsDefault
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cle_pkg::CfgIdxW-1:0]         i_cfg_idx,
    input  logic [cle_pkg::CfgDataW-1:0]        i_cfg_data,
    input  cle_pkg::t_in_item                   i_in,
    input  logic [((TAPS > 1) ? $clog2(TAPS) : 1)-1:0] i_tap,
    input  cle_pkg::t_dp_cmd                    i_cmd,
    output cle_pkg::t_out_item                  o_out
);
    import cle_pkg::*;

    logic signed [15:0] r_line_re [TAPS];
    logic signed [15:0] r_line_im [TAPS];
    logic signed [15:0] r_coef_re [TAPS];
    logic signed [15:0] r_coef_im [TAPS];
    logic signed [15:0] r_step_re, r_step_im;
    logic signed [15:0] r_des_re, r_des_im;
    logic signed [31:0] r_acc;
    logic signed [15:0] r_y_re, r_y_im, r_er, r_ei;
    logic signed [15:0] r_a, r_b, r_c, r_d;
    t_out_item          r_out;

    logic signed [15:0] w_xr, w_xi, w_cr, w_ci;
    logic signed [15:0] w_m0a, w_m0b, w_m1a, w_m1b;
    logic signed [15:0] w_m2a, w_m2b, w_m3a, w_m3b;
    logic signed [31:0] w_p0, w_p1, w_p2, w_p3, w_s0, w_s1, w_acc_next;
    logic signed [15:0] w_t_re, w_t_im, w_y;

    assign w_xr = r_line_re[i_tap];
    assign w_xi = r_line_im[i_tap];
    assign w_cr = r_coef_re[i_tap];
    assign w_ci = r_coef_im[i_tap];

    // operand selection for the two multiplier lanes
    always_comb begin
        unique case (i_cmd.op)
            OP_ACC_IM: begin w_m0a = w_ci;  w_m0b = w_xr;  w_m1a = w_cr;  w_m1b = w_xi;  end
            OP_STEPS:  begin w_m0a = r_er;  w_m0b = r_step_re; w_m1a = r_ei; w_m1b = r_step_re; end
            OP_UPD:    begin w_m0a = r_a;   w_m0b = w_xr;  w_m1a = r_b;   w_m1b = w_xi;  end
            default:   begin w_m0a = w_cr;  w_m0b = w_xr;  w_m1a = w_ci;  w_m1b = w_xi;  end
        endcase
    end

    // operand selection for the second multiplier pair
    always_comb begin
        if (i_cmd.op == OP_STEPS) begin
            w_m2a = r_er;  w_m2b = r_step_im;  w_m3a = r_ei;  w_m3b = r_step_im;
        end else begin
            w_m2a = r_d;   w_m2b = w_xr;       w_m3a = r_c;   w_m3b = w_xi;
        end
    end

    assign w_p0 = fmul(w_m0a, w_m0b);
    assign w_p1 = fmul(w_m1a, w_m1b);
    assign w_p2 = fmul(w_m2a, w_m2b);
    assign w_p3 = fmul(w_m3a, w_m3b);

    // accumulate passes: first product adds, second adds or subtracts
    always_comb begin
        w_s0 = sat32({r_acc[31], r_acc} + {w_p0[31], w_p0});
        if (i_cmd.op == OP_ACC_RE) w_acc_next = sat32({w_s0[31], w_s0} - {w_p1[31], w_p1});
        else w_acc_next = sat32({w_s0[31], w_s0} + {w_p1[31], w_p1});
    end

    assign w_y  = rnd15(r_acc);
    // update terms use a second multiplier pair for the imaginary part
    assign w_s1   = sat32({w_p0[31], w_p0} - {w_p1[31], w_p1});
    assign w_t_re = rnd15(w_s1);
    assign w_t_im = rnd15(sat32({w_p2[31], w_p2} + {w_p3[31], w_p3}));

    // step size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_re <= '0;
            r_step_im <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_STEP_RE) r_step_re <= i_cfg_data;
            if (i_cfg_idx == REG_STEP_IM) r_step_im <= i_cfg_data;
        end
    end

    // line, coefficients and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS; k++) begin
                r_line_re[k] <= '0;
                r_line_im[k] <= '0;
                r_coef_re[k] <= '0;
                r_coef_im[k] <= '0;
            end
        end else begin
            unique case (i_cmd.op)
                OP_SHIFT: begin
                    for (int k = TAPS - 1; k > 0; k--) begin
                        r_line_re[k] <= r_line_re[k-1];
                        r_line_im[k] <= r_line_im[k-1];
                    end
                    r_line_re[0] <= i_in.rx_re;
                    r_line_im[0] <= i_in.rx_im;
                    r_des_re     <= i_in.desired_re;
                    r_des_im     <= i_in.desired_im;
                    r_acc        <= '0;
                end
                OP_ACC_RE: begin
                    if (i_tap == ((TAPS > 1) ? $clog2(TAPS) : 1)'(TAPS - 1)) begin
                        r_y_re <= rnd15(w_acc_next);
                        r_acc  <= '0;
                    end else r_acc <= w_acc_next;
                end
                OP_ACC_IM: r_acc <= w_acc_next;
                OP_ERR: begin
                    r_y_im <= w_y;
                    r_er   <= sat16({r_des_re[15], r_des_re} - {r_y_re[15], r_y_re});
                    r_ei   <= sat16({r_des_im[15], r_des_im} - {w_y[15], w_y});
                end
                OP_STEPS: begin
                    r_a <= w_p0[31:16];
                    r_b <= w_p1[31:16];
                    r_c <= w_p2[31:16];
                    r_d <= w_p3[31:16];
                end
                OP_UPD: begin
                    r_coef_re[i_tap] <= sat16({w_cr[15], w_cr} - {w_t_re[15], w_t_re});
                    r_coef_im[i_tap] <= sat16({w_ci[15], w_ci} - {w_t_im[15], w_t_im});
                end
                // result register, held until its transfer
                OP_OUT: r_out <= '{y_re: r_y_re, y_im: r_y_im, err_re: r_er, err_im: r_ei};
                default: ;
            endcase
        end
    end

    assign o_out = r_out;

endmodule

@@ src/complex_lms_equalizer.sv @@
// ----------------------------------------------------------------------------
// complex_lms_equalizer
// Complex Q15 LMS adaptive FIR equalizer, top level.
// ----------------------------------------------------------------------------
// One item at a time: a symbol passes through the shared complex MAC lanes
// in order: the accept cycle, one pass of TAPS taps for each output part,
// the error and the step products, a coefficient update pass of TAPS taps,
// then the result register load. The input is stalled while an item is in
// work. The result sits in its own register until its transfer, so the next
// symbol can be worked meanwhile; it only waits before its result load if
// the earlier result is still held.
module complex_lms_equalizer #(
    parameter int unsigned TAPS = cle_pkg::TapsDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [cle_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [cle_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  cle_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output cle_pkg::t_out_item           o_out_data
);
    import cle_pkg::*;

    localparam int unsigned TapW = (TAPS > 1) ? $clog2(TAPS) : 1;

    logic [TapW-1:0] w_tap;
    t_dp_cmd         w_cmd;

    cle_ctrl #(.TAPS(TAPS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_tap      (w_tap),
        .o_cmd      (w_cmd)
    );

    cle_dp #(.TAPS(TAPS)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (i_in_data),
        .i_tap     (w_tap),
        .i_cmd     (w_cmd),
        .o_out     (o_out_data)
    );

endmodule
